/* rtl/page_frame_table_lru_assert.svh */
// Assertion macros shared by the page frame table RTL.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef PAGE_FRAME_TABLE_LRU_ASSERT_SVH
`define PAGE_FRAME_TABLE_LRU_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define PFT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("page frame table: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define PFT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("page frame table: next-cycle check failed");

`endif

/* rtl/pft_pkg.sv */
`timescale 1ns / 1ps

package pft_pkg;

    // Widths of the beat fields.
    localparam int PAGE_FIELD_W  = 20;
    localparam int PROC_FIELD_W  = 8;
    localparam int STAMP_FIELD_W = 32;
    localparam int COUNT_FIELD_W = 7;

    // Slot indexes and counts are carried wide enough for the largest table (1024 slots).
    localparam int IDX_MAX_W = 10;
    localparam int CNT_MAX_W = 11;

    typedef enum logic [1:0] {
        MODE_LOOKUP  = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_DELETE  = 2'd2,
        MODE_REPLACE = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic [PAGE_FIELD_W-1:0]  page;
        logic [PROC_FIELD_W-1:0]  proc_id;
        logic [STAMP_FIELD_W-1:0] stamp;
        logic                     is_write;
    } t_req;

    typedef struct packed {
        logic                     found;
        logic [STAMP_FIELD_W-1:0] hit_stamp;
        logic                     hit_dirty;
        logic                     victim_valid;
        logic [PAGE_FIELD_W-1:0]  victim_page;
        logic [PROC_FIELD_W-1:0]  victim_proc;
        logic                     victim_dirty;
        logic                     table_full;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } t_res;

    // Key that every cell compares against during a scan.
    typedef struct packed {
        logic [PAGE_FIELD_W-1:0] page;
        logic [PROC_FIELD_W-1:0] proc_id;
    } t_key;

    // Update broadcast to the row of cells at the end of an operation.
    typedef struct packed {
        logic                     set;
        logic                     clr;
        logic [IDX_MAX_W-1:0]     idx;
        logic [PAGE_FIELD_W-1:0]  page;
        logic [PROC_FIELD_W-1:0]  proc_id;
        logic [STAMP_FIELD_W-1:0] stamp;
        logic                     dirty;
    } t_wr;

    // Running search record handed from cell to cell.
    typedef struct packed {
        logic                     active;
        logic [CNT_MAX_W-1:0]     count;
        logic                     hit;
        logic [IDX_MAX_W-1:0]     hit_idx;
        logic [STAMP_FIELD_W-1:0] hit_stamp;
        logic                     hit_dirty;
        logic                     free_ok;
        logic [IDX_MAX_W-1:0]     free_idx;
        logic                     old_ok;
        logic [IDX_MAX_W-1:0]     old_idx;
        logic [STAMP_FIELD_W-1:0] old_stamp;
        logic [PAGE_FIELD_W-1:0]  old_page;
        logic [PROC_FIELD_W-1:0]  old_proc;
        logic                     old_dirty;
    } t_carry;

endpackage

/* rtl/pft_cell.sv */
`timescale 1ns / 1ps

// One frame slot. It folds its own entry into the search record and passes it on through its own register.
module pft_cell #(
    parameter int CELL_IDX = 0,
    parameter int PAGE_W   = 20
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pft_pkg::t_key   i_key,
    input  pft_pkg::t_wr    i_wr,
    input  pft_pkg::t_carry i_carry,
    output pft_pkg::t_carry o_carry
);

    localparam logic [pft_pkg::IDX_MAX_W-1:0] MY_IDX = pft_pkg::IDX_MAX_W'(CELL_IDX);

    logic                              r_valid;
    logic [PAGE_W-1:0]                 r_page;
    logic [pft_pkg::PROC_FIELD_W-1:0]  r_proc;
    logic [pft_pkg::STAMP_FIELD_W-1:0] r_stamp;
    logic                              r_dirty;
    pft_pkg::t_carry                   r_carry;
    pft_pkg::t_carry                   n_carry;
    logic                              w_match;
    logic                              w_sel;

    assign w_match = r_valid && (r_page == i_key.page[PAGE_W-1:0]) && (r_proc == i_key.proc_id);
    assign w_sel   = (i_wr.idx == MY_IDX);

    always_comb begin
        n_carry = i_carry;
        if (i_carry.active) begin
            n_carry.count = i_carry.count + pft_pkg::CNT_MAX_W'(r_valid);
            if (!i_carry.hit && w_match) begin
                n_carry.hit       = 1'b1;
                n_carry.hit_idx   = MY_IDX;
                n_carry.hit_stamp = r_stamp;
                n_carry.hit_dirty = r_dirty;
            end
            if (!i_carry.free_ok && !r_valid) begin
                n_carry.free_ok  = 1'b1;
                n_carry.free_idx = MY_IDX;
            end
            // Strictly less keeps the lowest slot on equal stamps.
            if (r_valid && (!i_carry.old_ok || (r_stamp < i_carry.old_stamp))) begin
                n_carry.old_ok    = 1'b1;
                n_carry.old_idx   = MY_IDX;
                n_carry.old_stamp = r_stamp;
                n_carry.old_page  = pft_pkg::PAGE_FIELD_W'(r_page);
                n_carry.old_proc  = r_proc;
                n_carry.old_dirty = r_dirty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_carry.active <= 1'b0;
        end else begin
            r_carry <= n_carry;
            if (w_sel && i_wr.set) begin
                r_valid <= 1'b1;
                r_page  <= i_wr.page[PAGE_W-1:0];
                r_proc  <= i_wr.proc_id;
                r_stamp <= i_wr.stamp;
                r_dirty <= i_wr.dirty;
            end else if (w_sel && i_wr.clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_carry = r_carry;

endmodule

/* rtl/page_frame_table_lru.sv */
`timescale 1ns / 1ps

// Page frame table with least-timestamp replacement. A command beat is taken when start is
// high and busy is low; busy then stays high until the result has been shown. Every command
// returns exactly one result beat, on o_res for a single cycle marked by o_res_valid, and the
// receiver cannot stall it, so it must take the beat in that cycle. From acceptance, a search
// record walks the row of FRAMES slot cells, one cell per cycle; then the result and the slot
// update are registered, and the chosen slot is written while the result is on the port. The
// next command is taken in the following cycle, the first with busy low. No clearing pass
// is needed after reset; the valid marks of all slots clear at once.
module page_frame_table_lru #(
    parameter int FRAMES    = 64,
    parameter int PAGE_BITS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pft_pkg::t_req i_req,
    output logic          o_res_valid,
    output pft_pkg::t_res o_res
);

    // Only the low PAGE_BITS bits of a page number take part, capped at the field width.
    localparam int PAGE_W = (PAGE_BITS < pft_pkg::PAGE_FIELD_W) ? PAGE_BITS
                                                                 : pft_pkg::PAGE_FIELD_W;
    localparam logic [pft_pkg::PAGE_FIELD_W-1:0] PAGE_MASK =
        pft_pkg::PAGE_FIELD_W'((64'd1 << PAGE_W) - 64'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    t_state          r_state;
    logic            r_launch;
    pft_pkg::t_req   r_req;
    pft_pkg::t_key   w_key;
    pft_pkg::t_wr    r_wr;
    pft_pkg::t_wr    n_wr;
    pft_pkg::t_res   r_res;
    pft_pkg::t_res   n_res;
    logic            r_res_valid;
    pft_pkg::t_carry w_head;
    pft_pkg::t_carry w_chain [FRAMES+1];
    pft_pkg::t_carry w_last;
    logic [pft_pkg::CNT_MAX_W-1:0] w_count;

    assign busy = (r_state != ST_IDLE);

    assign w_key.page    = r_req.page;
    assign w_key.proc_id = r_req.proc_id;

    // The search record enters the first cell empty, tagged active for one cycle.
    always_comb begin
        w_head        = '0;
        w_head.active = r_launch;
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        pft_cell #(
            .CELL_IDX (g),
            .PAGE_W   (PAGE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (w_key),
            .i_wr    (r_wr),
            .i_carry (w_chain[g]),
            .o_carry (w_chain[g+1])
        );
    end

    assign w_last = w_chain[FRAMES];

    // Decide the result beat and the slot update from the finished search record.
    always_comb begin
        n_res         = '0;
        n_wr          = '0;
        n_wr.page     = r_req.page;
        n_wr.proc_id  = r_req.proc_id;
        n_wr.stamp    = r_req.stamp;
        n_wr.dirty    = r_req.is_write;
        w_count       = w_last.count;
        case (r_req.mode)
            pft_pkg::MODE_LOOKUP: begin
                n_res.found     = w_last.hit;
                n_res.hit_stamp = w_last.hit ? w_last.hit_stamp : '0;
                n_res.hit_dirty = w_last.hit && w_last.hit_dirty;
            end
            pft_pkg::MODE_INSERT: begin
                if (w_last.free_ok) begin
                    n_wr.set = 1'b1;
                    n_wr.idx = w_last.free_idx;
                    w_count  = w_last.count + pft_pkg::CNT_MAX_W'(1);
                end else begin
                    n_res.table_full = 1'b1;
                end
            end
            pft_pkg::MODE_DELETE: begin
                n_res.found     = w_last.hit;
                n_res.hit_stamp = w_last.hit ? w_last.hit_stamp : '0;
                n_res.hit_dirty = w_last.hit && w_last.hit_dirty;
                if (w_last.hit) begin
                    n_wr.clr = 1'b1;
                    n_wr.idx = w_last.hit_idx;
                    w_count  = w_last.count - pft_pkg::CNT_MAX_W'(1);
                end
            end
            pft_pkg::MODE_REPLACE: begin
                if (w_last.old_ok) begin
                    n_res.victim_valid = 1'b1;
                    n_res.victim_page  = w_last.old_page;
                    n_res.victim_proc  = w_last.old_proc;
                    n_res.victim_dirty = w_last.old_dirty;
                    n_wr.set           = 1'b1;
                    n_wr.idx           = w_last.old_idx;
                end else if (w_last.free_ok) begin
                    // Empty table: the new key simply takes the lowest free slot.
                    n_wr.set = 1'b1;
                    n_wr.idx = w_last.free_idx;
                    w_count  = w_last.count + pft_pkg::CNT_MAX_W'(1);
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
        n_res.entry_count = w_count[pft_pkg::COUNT_FIELD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_res_valid <= 1'b0;
            r_wr.set    <= 1'b0;
            r_wr.clr    <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_req    <= pft_pkg::t_req'{i_req.mode, i_req.page & PAGE_MASK,
                                                    i_req.proc_id, i_req.stamp,
                                                    i_req.is_write};
                        r_launch <= 1'b1;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // The launch mark lasts one cycle, so a single record walks the row.
                    r_launch <= 1'b0;
                    if (w_last.active) begin
                        r_res       <= n_res;
                        r_res_valid <= 1'b1;
                        r_wr        <= n_wr;
                        r_state     <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    // The cells take the update at the end of this cycle.
                    r_res_valid <= 1'b0;
                    r_wr.set    <= 1'b0;
                    r_wr.clr    <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_launch    <= 1'b0;
                    r_res_valid <= 1'b0;
                    r_wr.set    <= 1'b0;
                    r_wr.clr    <= 1'b0;
                    r_state     <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`include "page_frame_table_lru_assert.svh"

    // An accepted command keeps the block busy in the next cycle.
    `PFT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // A result beat is only shown while the command that caused it still holds the block.
    `PFT_ASSERT_SAME(a_res_in_commit, i_clk, i_rst_n, o_res_valid, busy && (r_state == ST_COMMIT))
    // A dropped insert reports neither a hit nor a victim.
    `PFT_ASSERT_SAME(a_full_clean, i_clk, i_rst_n, o_res_valid && o_res.table_full,
        !o_res.found && !o_res.victim_valid)
    // The slot update is issued together with its result beat and never on its own.
    `PFT_ASSERT_SAME(a_wr_with_res, i_clk, i_rst_n, r_wr.set || r_wr.clr, o_res_valid)

endmodule
